// File: hdl/fcbd_pkg.sv
// Shared constants, widths and the heading rotation table of the bias direction block.
package fcbd_pkg;

    localparam int DirFracBits = 14;
    localparam int CordicSteps = 16;
    localparam logic signed [33:0] CordicStart = 34'sd652032874;

    // Widths of the internal vectors.
    localparam int A_W = 18;
    localparam int B_W = 16;
    localparam int C_W = 21;
    localparam int R_W = 24;
    localparam int S_W = 26;
    localparam int D_W = 16;
    localparam int V_W = 32;

    localparam logic signed [15:0] RndF = 16'sd1 <<< (DirFracBits - 1);
    localparam logic signed [15:0] Rnd15 = 16'sd16384;

    // Stage counts of each pipelined unit.
    localparam int CordicLat = CordicSteps + 2;
    localparam int SplitLat = 4;
    localparam int BlendLat = 6;
    localparam int NormLat = 54;
    localparam int ThetaLat = 2;
    localparam int SpeedLat = 3;
    localparam int TotalLat = CordicLat + 2 * (SplitLat + NormLat + BlendLat + NormLat);

    function automatic logic signed [33:0] atan_turn(input logic [3:0] idx);
        logic signed [33:0] v;
        case (idx)
            4'd0:    v = 34'sd536870912;
            4'd1:    v = 34'sd316933406;
            4'd2:    v = 34'sd167458907;
            4'd3:    v = 34'sd85004756;
            4'd4:    v = 34'sd42667336;
            4'd5:    v = 34'sd21354465;
            4'd6:    v = 34'sd10679838;
            4'd7:    v = 34'sd5340245;
            4'd8:    v = 34'sd2670163;
            4'd9:    v = 34'sd1335087;
            4'd10:   v = 34'sd667544;
            4'd11:   v = 34'sd333772;
            4'd12:   v = 34'sd166886;
            4'd13:   v = 34'sd83443;
            4'd14:   v = 34'sd41722;
            4'd15:   v = 34'sd20861;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/fiber_chemotaxis_bias_direction_top.sv
// Top level of the migration bias direction and speed pipeline.
// One item is accepted per clock while the pipeline is not held, and its result is presented
// in the output register once it has passed 254 pipeline stages; the depth is set by the
// four chained vector normalizers (each with a 32-stage square root followed by a 15-stage
// divider), with the 18-stage heading rotation in front and the projection and blend stages
// between them. The whole pipeline advances together and holds only when a result waits
// in the output register and another one has reached the end of the pipeline.
module fiber_chemotaxis_bias_direction_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // heading_phase, fiber_x, fiber_y, anisotropy, ecm_density, grad_x, grad_y
    input  logic [143:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // dir_x, dir_y, bias_level, speed
    output logic [63:0]   m_axis_tdata,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_addr,
    input  logic [15:0]   i_cfg_wdata
);
    import fcbd_pkg::*;

    typedef enum logic [1:0] {
        CFG_MAX_SPEED    = 2'd0,
        CFG_BIAS         = 2'd1,
        CFG_FIBER_SENS   = 2'd2,
        CFG_CHEMO_WEIGHT = 2'd3
    } t_cfg_idx;

    localparam int T2 = CordicLat + SplitLat + 2 * NormLat + BlendLat;

    logic [15:0] r_max_speed, r_bias, r_fiber_sens, r_chemo_weight;

    logic        w_en, w_last_valid;
    logic        r_out_valid;
    logic [15:0] r_out_dx, r_out_dy, r_out_bias, r_out_speed;

    logic [15:0]           w_phase, w_aniso, w_dens;
    logic signed [B_W-1:0] w_fx, w_fy, w_fdx, w_fdy, w_f2x, w_f2y;
    logic signed [V_W-1:0] w_gradx, w_grady;

    logic signed [A_W-1:0] w_cos, w_sin, w_d2x, w_d2y;
    logic signed [C_W-1:0] w_c2, w_c2d, w_c4, w_c4d;
    logic signed [R_W-1:0] w_r1x, w_r1y, w_r2x, w_r2y;
    logic signed [D_W-1:0] w_px, w_py, w_nx, w_ny, w_gx, w_gy, w_gdx, w_gdy;
    logic signed [D_W-1:0] w_qx, w_qy, w_rx, w_ry, w_n2x, w_n2y, w_g2x, w_g2y;
    logic signed [S_W-1:0] w_s1x, w_s1y, w_s2x, w_s2y;

    logic [31:0] r_th_prod;
    logic [17:0] w_theta;
    logic [15:0] r_k1, w_k1d, w_k2, w_chemo_sat;

    logic [31:0] r_sp_p1;
    logic [15:0] r_sp_om;
    logic        r_sp_z1, r_sp_z2;
    logic [47:0] r_sp_p2;
    logic [19:0] w_sp;
    logic [15:0] r_spd, w_spd_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed    <= 16'd64;
            r_bias         <= 16'd0;
            r_fiber_sens   <= 16'd32768;
            r_chemo_weight <= 16'd16384;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_MAX_SPEED:    r_max_speed    <= i_cfg_wdata;
                CFG_BIAS:         r_bias         <= i_cfg_wdata;
                CFG_FIBER_SENS:   r_fiber_sens   <= i_cfg_wdata;
                CFG_CHEMO_WEIGHT: r_chemo_weight <= i_cfg_wdata;
                default:          r_bias         <= r_bias;
            endcase
        end
    end

    assign w_phase = s_axis_tdata[15:0];
    assign w_fx    = signed'(s_axis_tdata[31:16]);
    assign w_fy    = signed'(s_axis_tdata[47:32]);
    assign w_aniso = s_axis_tdata[63:48];
    assign w_dens  = s_axis_tdata[79:64];
    assign w_gradx = signed'(s_axis_tdata[111:80]);
    assign w_grady = signed'(s_axis_tdata[143:112]);

    assign w_en = !(r_out_valid && !m_axis_tready && w_last_valid);
    assign s_axis_tready = w_en;

    fcbd_delay #(.W(1), .D(TotalLat)) u_vld (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_d(s_axis_tvalid), .o_q(w_last_valid)
    );

    // Fiber stage.
    fcbd_cordic u_cordic (
        .i_clk(i_clk), .i_en(w_en), .i_phase(w_phase), .o_cos(w_cos), .o_sin(w_sin)
    );

    fcbd_delay #(.W(2 * B_W), .D(CordicLat)) u_dl_f (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_d({w_fy, w_fx}), .o_q({w_fdy, w_fdx})
    );

    fcbd_split u_split1 (
        .i_clk(i_clk), .i_en(w_en), .i_ax(w_cos), .i_ay(w_sin), .i_bx(w_fdx), .i_by(w_fdy),
        .o_c(w_c2), .o_rx(w_r1x), .o_ry(w_r1y)
    );

    fcbd_norm u_norm_p (
        .i_clk(i_clk), .i_en(w_en), .i_vx(V_W'(w_r1x)), .i_vy(V_W'(w_r1y)),
        .o_x(w_px), .o_y(w_py)
    );

    fcbd_delay #(.W(2 * A_W + 2 * B_W), .D(SplitLat + NormLat)) u_dl_df (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_d({w_sin, w_cos, w_fdy, w_fdx}), .o_q({w_d2y, w_d2x, w_f2y, w_f2x})
    );

    fcbd_delay #(.W(C_W), .D(NormLat)) u_dl_c2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_d(w_c2), .o_q(w_c2d)
    );

    always_comb begin
        w_theta = 18'((33'(r_th_prod) + 33'd16384) >> 15);
        w_chemo_sat = (r_chemo_weight > 16'd32768) ? 16'd32768 : r_chemo_weight;
        w_k2 = 16'd32768 - w_chemo_sat;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_th_prod <= w_aniso * r_fiber_sens;
            r_k1 <= (w_theta > 18'd32768) ? 16'd0 : 16'(18'd32768 - w_theta);
        end
    end

    fcbd_delay #(.W(16), .D(CordicLat + SplitLat + NormLat - ThetaLat)) u_dl_k1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_d(r_k1), .o_q(w_k1d)
    );

    fcbd_blend u_blend1 (
        .i_clk(i_clk), .i_en(w_en), .i_ax(w_d2x), .i_ay(w_d2y), .i_px(w_px), .i_py(w_py),
        .i_c(w_c2d), .i_bx(w_f2x), .i_by(w_f2y), .i_k(w_k1d), .o_sx(w_s1x), .o_sy(w_s1y)
    );

    fcbd_norm u_norm_n (
        .i_clk(i_clk), .i_en(w_en), .i_vx(V_W'(w_s1x)), .i_vy(V_W'(w_s1y)),
        .o_x(w_nx), .o_y(w_ny)
    );

    // Chemotaxis stage.
    fcbd_norm u_norm_g (
        .i_clk(i_clk), .i_en(w_en), .i_vx(w_gradx), .i_vy(w_grady), .o_x(w_gx), .o_y(w_gy)
    );

    fcbd_delay #(.W(2 * D_W), .D(T2 - NormLat)) u_dl_g (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_d({w_gy, w_gx}), .o_q({w_gdy, w_gdx})
    );

    fcbd_split u_split2 (
        .i_clk(i_clk), .i_en(w_en), .i_ax(A_W'(w_nx)), .i_ay(A_W'(w_ny)),
        .i_bx(w_gdx), .i_by(w_gdy), .o_c(w_c4), .o_rx(w_r2x), .o_ry(w_r2y)
    );

    fcbd_norm u_norm_q (
        .i_clk(i_clk), .i_en(w_en), .i_vx(V_W'(w_r2x)), .i_vy(V_W'(w_r2y)),
        .o_x(w_qx), .o_y(w_qy)
    );

    fcbd_delay #(.W(4 * D_W), .D(SplitLat + NormLat)) u_dl_ng (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_d({w_ny, w_nx, w_gdy, w_gdx}), .o_q({w_n2y, w_n2x, w_g2y, w_g2x})
    );

    fcbd_delay #(.W(C_W), .D(NormLat)) u_dl_c4 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_d(w_c4), .o_q(w_c4d)
    );

    fcbd_blend u_blend2 (
        .i_clk(i_clk), .i_en(w_en), .i_ax(A_W'(w_n2x)), .i_ay(A_W'(w_n2y)),
        .i_px(w_qx), .i_py(w_qy), .i_c(w_c4d), .i_bx(w_g2x), .i_by(w_g2y), .i_k(w_k2),
        .o_sx(w_s2x), .o_sy(w_s2y)
    );

    fcbd_norm u_norm_r (
        .i_clk(i_clk), .i_en(w_en), .i_vx(V_W'(w_s2x)), .i_vy(V_W'(w_s2y)),
        .o_x(w_rx), .o_y(w_ry)
    );

    // Speed.
    assign w_sp = 20'((r_sp_p2 + 48'd134217728) >> 28);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sp_p1 <= r_max_speed * w_dens;
            r_sp_om <= 16'(17'd32768 - {1'b0, w_dens});
            r_sp_z1 <= w_dens[15];
            r_sp_p2 <= r_sp_p1 * r_sp_om;
            r_sp_z2 <= r_sp_z1;
            r_spd   <= r_sp_z2 ? 16'd0 : ((w_sp > 20'd65535) ? 16'hFFFF : w_sp[15:0]);
        end
    end

    fcbd_delay #(.W(16), .D(TotalLat - SpeedLat)) u_dl_spd (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_d(r_spd), .o_q(w_spd_d)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en && w_last_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_last_valid) begin
            r_out_dx    <= w_rx;
            r_out_dy    <= w_ry;
            r_out_bias  <= r_bias;
            r_out_speed <= w_spd_d;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_speed, r_out_bias, r_out_dy, r_out_dx};

    a_stall_keeps_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready && w_last_valid) |=> w_last_valid)
        else $error("stalled item left the end of the pipeline");

    a_dir_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(r_out_dx) >= -16'sd16384 && $signed(r_out_dx) <= 16'sd16384))
        else $error("dir_x beyond unit length");

    a_dir_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(r_out_dy) >= -16'sd16384 && $signed(r_out_dy) <= 16'sd16384))
        else $error("dir_y beyond unit length");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result shown right after reset");
endmodule

// File: hdl/fcbd_delay.sv
// Enabled shift line that carries data alongside the pipelined units.
module fcbd_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_tap [D];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < D; k++) r_tap[k] <= '0;
        end else if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < D; k++) r_tap[k] <= r_tap[k-1];
        end
    end

    assign o_q = r_tap[D-1];
endmodule

// File: hdl/fcbd_cordic.sv
// Pipelined rotation unit that turns a heading phase into its cosine and sine.
module fcbd_cordic (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [15:0]                       i_phase,
    output logic signed [fcbd_pkg::A_W-1:0]   o_cos,
    output logic signed [fcbd_pkg::A_W-1:0]   o_sin
);
    import fcbd_pkg::*;

    localparam int Sh = 30 - DirFracBits;
    localparam logic signed [33:0] RndC = 34'sd1 <<< (Sh - 1);

    logic signed [33:0] r_x [CordicSteps+1];
    logic signed [33:0] r_y [CordicSteps+1];
    logic signed [33:0] r_z [CordicSteps+1];
    logic signed [33:0] w_z0, n_x0, n_z0;
    logic signed [33:0] w_cr, w_sr;
    logic signed [A_W-1:0] r_cos, r_sin;

    always_comb begin
        w_z0 = 34'(signed'({i_phase, 16'h0000}));
        n_x0 = CordicStart;
        n_z0 = w_z0;
        if (w_z0 > 34'sd1073741824) begin
            n_x0 = -CordicStart;
            n_z0 = w_z0 - 34'sd2147483648;
        end else if (w_z0 < -34'sd1073741824) begin
            n_x0 = -CordicStart;
            n_z0 = w_z0 + 34'sd2147483648;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= n_x0;
            r_y[0] <= '0;
            r_z[0] <= n_z0;
        end
    end

    for (genvar i = 0; i < CordicSteps; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_turn(4'(i));
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_turn(4'(i));
                end
            end
        end
    end

    always_comb begin
        w_cr = (r_x[CordicSteps] + RndC) >>> Sh;
        w_sr = (r_y[CordicSteps] + RndC) >>> Sh;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= A_W'(w_cr);
            r_sin <= A_W'(w_sr);
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;
endmodule

// File: hdl/fcbd_split.sv
// Projects a vector on an axis and removes that part, giving the dot product and the remainder.
module fcbd_split (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [fcbd_pkg::A_W-1:0] i_ax,
    input  logic signed [fcbd_pkg::A_W-1:0] i_ay,
    input  logic signed [fcbd_pkg::B_W-1:0] i_bx,
    input  logic signed [fcbd_pkg::B_W-1:0] i_by,
    output logic signed [fcbd_pkg::C_W-1:0] o_c,
    output logic signed [fcbd_pkg::R_W-1:0] o_rx,
    output logic signed [fcbd_pkg::R_W-1:0] o_ry
);
    import fcbd_pkg::*;

    logic signed [A_W+B_W-1:0] r_pax, r_pay;
    logic signed [A_W-1:0]     r_ax1, r_ay1, r_ax2, r_ay2, r_ax3, r_ay3;
    logic signed [B_W-1:0]     r_bx1, r_by1, r_bx2, r_by2;
    logic signed [C_W-1:0]     r_c2, r_c3, r_c4;
    logic signed [C_W+B_W-1:0] r_cbx, r_cby;
    logic signed [R_W-1:0]     r_rx, r_ry;
    logic signed [A_W+B_W:0]   w_dot;
    logic signed [C_W+B_W:0]   w_rx, w_ry;

    always_comb begin
        w_dot = r_pax + r_pay + RndF;
        w_rx = r_cbx + RndF;
        w_ry = r_cby + RndF;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pax <= i_ax * i_bx;
            r_pay <= i_ay * i_by;
            r_ax1 <= i_ax;
            r_ay1 <= i_ay;
            r_bx1 <= i_bx;
            r_by1 <= i_by;

            r_c2  <= C_W'(w_dot >>> DirFracBits);
            r_ax2 <= r_ax1;
            r_ay2 <= r_ay1;
            r_bx2 <= r_bx1;
            r_by2 <= r_by1;

            r_cbx <= r_c2 * r_bx2;
            r_cby <= r_c2 * r_by2;
            r_c3  <= r_c2;
            r_ax3 <= r_ax2;
            r_ay3 <= r_ay2;

            r_rx  <= R_W'(r_ax3 - (w_rx >>> DirFracBits));
            r_ry  <= R_W'(r_ay3 - (w_ry >>> DirFracBits));
            r_c4  <= r_c3;
        end
    end

    assign o_c  = r_c4;
    assign o_rx = r_rx;
    assign o_ry = r_ry;
endmodule

// File: hdl/fcbd_blend.sv
// Damps the across part of a vector and adds back its part along the axis.
module fcbd_blend (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [fcbd_pkg::A_W-1:0] i_ax,
    input  logic signed [fcbd_pkg::A_W-1:0] i_ay,
    input  logic signed [fcbd_pkg::D_W-1:0] i_px,
    input  logic signed [fcbd_pkg::D_W-1:0] i_py,
    input  logic signed [fcbd_pkg::C_W-1:0] i_c,
    input  logic signed [fcbd_pkg::B_W-1:0] i_bx,
    input  logic signed [fcbd_pkg::B_W-1:0] i_by,
    input  logic [15:0]                     i_k,
    output logic signed [fcbd_pkg::S_W-1:0] o_sx,
    output logic signed [fcbd_pkg::S_W-1:0] o_sy
);
    import fcbd_pkg::*;

    logic signed [A_W+D_W-1:0]   r_apx, r_apy;
    logic signed [D_W-1:0]       r_px [1:4];
    logic signed [D_W-1:0]       r_py [1:4];
    logic signed [C_W-1:0]       r_c [1:4];
    logic signed [B_W-1:0]       r_bx [1:4];
    logic signed [B_W-1:0]       r_by [1:4];
    logic [15:0]                 r_k1, r_k2;
    logic signed [C_W-1:0]       r_c1;
    logic signed [C_W+16:0]      r_ck;
    logic signed [C_W+1:0]       r_a1;
    logic signed [C_W+D_W+1:0]   r_ax5, r_ay5;
    logic signed [C_W+B_W-1:0]   r_cbx5, r_cby5;
    logic signed [S_W-1:0]       r_sx, r_sy;
    logic signed [A_W+D_W:0]     w_dot;
    logic signed [C_W+17:0]      w_ck;
    logic signed [C_W+D_W+2:0]   w_sx, w_sy;

    always_comb begin
        w_dot = r_apx + r_apy + RndF;
        w_ck = r_ck + Rnd15;
        w_sx = r_ax5 + r_cbx5 + RndF;
        w_sy = r_ay5 + r_cby5 + RndF;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_apx <= i_ax * i_px;
            r_apy <= i_ay * i_py;
            r_px[1] <= i_px;
            r_py[1] <= i_py;
            r_c[1]  <= i_c;
            r_bx[1] <= i_bx;
            r_by[1] <= i_by;
            r_k1    <= i_k;
            for (int s = 2; s <= 4; s++) begin
                r_px[s] <= r_px[s-1];
                r_py[s] <= r_py[s-1];
                r_c[s]  <= r_c[s-1];
                r_bx[s] <= r_bx[s-1];
                r_by[s] <= r_by[s-1];
            end

            r_c1 <= C_W'(w_dot >>> DirFracBits);
            r_k2 <= r_k1;

            r_ck <= r_c1 * signed'({1'b0, r_k2});

            r_a1 <= (C_W+2)'(w_ck >>> 15);

            r_ax5  <= r_a1 * r_px[4];
            r_ay5  <= r_a1 * r_py[4];
            r_cbx5 <= r_c[4] * r_bx[4];
            r_cby5 <= r_c[4] * r_by[4];

            r_sx <= S_W'(w_sx >>> DirFracBits);
            r_sy <= S_W'(w_sy >>> DirFracBits);
        end
    end

    assign o_sx = r_sx;
    assign o_sy = r_sy;
endmodule

// File: hdl/fcbd_norm.sv
// Pipelined vector normalizer: scaling, squares, square root and two rounding dividers.
module fcbd_norm (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [fcbd_pkg::V_W-1:0] i_vx,
    input  logic signed [fcbd_pkg::V_W-1:0] i_vy,
    output logic signed [fcbd_pkg::D_W-1:0] o_x,
    output logic signed [fcbd_pkg::D_W-1:0] o_y
);
    import fcbd_pkg::*;

    localparam int QW = DirFracBits + 1;
    localparam int NumW = 32 + DirFracBits;

    logic [31:0] w_ax, w_ay;
    logic [31:0] r_ax0, r_ay0, r_m0;
    logic        r_sx0, r_sy0;

    logic [30:0] w_ax1, w_ay1, w_m1;
    logic [4:0]  w_lz;
    logic [30:0] r_ax1, r_ay1;
    logic [4:0]  r_lz1;
    logic        r_sx1, r_sy1, r_z1;

    logic [30:0] r_ax2, r_ay2;
    logic        r_sx2, r_sy2, r_z2;

    logic [61:0] r_sqx, r_sqy;
    logic [30:0] r_ax3, r_ay3;
    logic        r_sx3, r_sy3, r_z3;

    logic [62:0] r_rem  [33];
    logic [31:0] r_root [33];
    logic [30:0] r_cx   [33];
    logic [30:0] r_cy   [33];
    logic        r_csx  [33];
    logic        r_csy  [33];
    logic        r_cz   [33];

    logic [NumW-1:0] r_dx   [QW+1];
    logic [NumW-1:0] r_dy   [QW+1];
    logic [QW-1:0]   r_qx   [QW+1];
    logic [QW-1:0]   r_qy   [QW+1];
    logic [31:0]     r_len  [QW+1];
    logic            r_dsx  [QW+1];
    logic            r_dsy  [QW+1];
    logic            r_dz   [QW+1];

    logic signed [D_W-1:0] w_qx, w_qy;
    logic signed [D_W-1:0] r_ox, r_oy;

    always_comb begin
        w_ax = i_vx[V_W-1] ? unsigned'(-i_vx) : unsigned'(i_vx);
        w_ay = i_vy[V_W-1] ? unsigned'(-i_vy) : unsigned'(i_vy);
        w_ax1 = r_m0[31] ? r_ax0[31:1] : r_ax0[30:0];
        w_ay1 = r_m0[31] ? r_ay0[31:1] : r_ay0[30:0];
        w_m1  = r_m0[31] ? r_m0[31:1] : r_m0[30:0];
        w_lz = '0;
        for (int b = 0; b < 31; b++) begin
            if (w_m1[b]) w_lz = 5'(30 - b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax0 <= w_ax;
            r_ay0 <= w_ay;
            r_m0  <= (w_ax > w_ay) ? w_ax : w_ay;
            r_sx0 <= i_vx[V_W-1];
            r_sy0 <= i_vy[V_W-1];

            r_ax1 <= w_ax1;
            r_ay1 <= w_ay1;
            r_lz1 <= w_lz;
            r_z1  <= (r_m0 == '0);
            r_sx1 <= r_sx0;
            r_sy1 <= r_sy0;

            r_ax2 <= r_ax1 << r_lz1;
            r_ay2 <= r_ay1 << r_lz1;
            r_z2  <= r_z1;
            r_sx2 <= r_sx1;
            r_sy2 <= r_sy1;

            r_sqx <= r_ax2 * r_ax2;
            r_sqy <= r_ay2 * r_ay2;
            r_ax3 <= r_ax2;
            r_ay3 <= r_ay2;
            r_z3  <= r_z2;
            r_sx3 <= r_sx2;
            r_sy3 <= r_sy2;

            r_rem[0]  <= {1'b0, r_sqx} + {1'b0, r_sqy};
            r_root[0] <= '0;
            r_cx[0]   <= r_ax3;
            r_cy[0]   <= r_ay3;
            r_csx[0]  <= r_sx3;
            r_csy[0]  <= r_sy3;
            r_cz[0]   <= r_z3;
        end
    end

    for (genvar k = 0; k < 32; k++) begin : g_sqrt
        localparam int Bit = 31 - k;
        logic [64:0] w_t;
        always_comb begin
            w_t = ({33'b0, r_root[k]} << (Bit + 1)) | (65'd1 << (2 * Bit));
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if ({2'b00, r_rem[k]} >= w_t) begin
                    r_rem[k+1]  <= r_rem[k] - 63'(w_t);
                    r_root[k+1] <= r_root[k] | (32'd1 << Bit);
                end else begin
                    r_rem[k+1]  <= r_rem[k];
                    r_root[k+1] <= r_root[k];
                end
                r_cx[k+1]  <= r_cx[k];
                r_cy[k+1]  <= r_cy[k];
                r_csx[k+1] <= r_csx[k];
                r_csy[k+1] <= r_csy[k];
                r_cz[k+1]  <= r_cz[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx[0]  <= ({(NumW-31)'(0), r_cx[32]} << DirFracBits) + NumW'(r_root[32] >> 1);
            r_dy[0]  <= ({(NumW-31)'(0), r_cy[32]} << DirFracBits) + NumW'(r_root[32] >> 1);
            r_qx[0]  <= '0;
            r_qy[0]  <= '0;
            r_len[0] <= r_root[32];
            r_dsx[0] <= r_csx[32];
            r_dsy[0] <= r_csy[32];
            r_dz[0]  <= r_cz[32];
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        localparam int Bit = QW - 1 - k;
        logic [NumW-1:0] w_d;
        always_comb begin
            w_d = {(NumW-32)'(0), r_len[k]} << Bit;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_dx[k] >= w_d) begin
                    r_dx[k+1] <= r_dx[k] - w_d;
                    r_qx[k+1] <= r_qx[k] | (QW'(1) << Bit);
                end else begin
                    r_dx[k+1] <= r_dx[k];
                    r_qx[k+1] <= r_qx[k];
                end
                if (r_dy[k] >= w_d) begin
                    r_dy[k+1] <= r_dy[k] - w_d;
                    r_qy[k+1] <= r_qy[k] | (QW'(1) << Bit);
                end else begin
                    r_dy[k+1] <= r_dy[k];
                    r_qy[k+1] <= r_qy[k];
                end
                r_len[k+1] <= r_len[k];
                r_dsx[k+1] <= r_dsx[k];
                r_dsy[k+1] <= r_dsy[k];
                r_dz[k+1]  <= r_dz[k];
            end
        end
    end

    always_comb begin
        w_qx = signed'(D_W'(r_qx[QW]));
        w_qy = signed'(D_W'(r_qy[QW]));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ox <= r_dz[QW] ? '0 : (r_dsx[QW] ? -w_qx : w_qx);
            r_oy <= r_dz[QW] ? '0 : (r_dsy[QW] ? -w_qy : w_qy);
        end
    end

    assign o_x = r_ox;
    assign o_y = r_oy;
endmodule
